>>> hw/rtl/dmct_pkg.sv
// dmct_pkg: shared types and constants for the direct-mapped cache hit tracker.
// No dependencies.

package dmct_pkg;

    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_COMPULSORY = 2'd1,
        OUT_CONFLICT   = 2'd2,
        OUT_CLEARED    = 2'd3
    } outcome_t;

    typedef enum logic {
        MODE_ACCESS = 1'b0,
        MODE_CLEAR  = 1'b1
    } mode_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] OFFSET_MIN   = 4'd4;
    localparam logic [CFG_DATA_W-1:0] OFFSET_MAX   = 4'd8;
    localparam logic [CFG_DATA_W-1:0] OFFSET_RESET = 4'd4;
    localparam logic [CFG_DATA_W-1:0] INDEX_MIN    = 4'd4;
    localparam logic [CFG_DATA_W-1:0] INDEX_MAX    = 4'd14;
    localparam logic [CFG_DATA_W-1:0] INDEX_RESET  = 4'd8;

    function automatic logic [CFG_DATA_W-1:0] clamp4(
        input logic [CFG_DATA_W-1:0] v,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi
    );
        logic [CFG_DATA_W-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/dmct_if.sv
// Handshake channel interfaces for the cache hit tracker: access, result, config.
// Depends on dmct_pkg.

interface dmct_access_if;
    import dmct_pkg::*;
    logic                valid;
    logic                ready;
    mode_t               mode;
    logic [ADDR_W-1:0]   address;
    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface dmct_result_if;
    import dmct_pkg::*;
    logic                valid;
    logic                ready;
    outcome_t            outcome;
    logic [COUNT_W-1:0]  hit_total;
    logic [COUNT_W-1:0]  miss_total;
    modport source (output valid, output outcome, output hit_total, output miss_total,
                    input ready);
    modport sink   (input valid, input outcome, input hit_total, input miss_total,
                    output ready);
endinterface

interface dmct_cfg_if;
    import dmct_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/dmct_ram.sv
// dmct_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module dmct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/direct_mapped_cache_hit_tracker.sv
// direct_mapped_cache_hit_tracker: direct-mapped tag store with hit/miss counting.
// Depends on dmct_pkg, dmct_if (access/result/cfg interfaces) and dmct_ram.
//
//  channel  | dir | payload                               | notes
//  ---------+-----+---------------------------------------+------------------------
//  access   | in  | mode, address[31:0]                   | one request per access
//  result   | out | outcome[1:0], hit_total, miss_total   | one result per request
//  cfg      | in  | index[1:0], data[3:0]                 | always ready
//
// Steps: an accepted request reads the tag RAM, then the compare stage compares
//   and writes back; no new request is taken until the compare stage retires.
// Reset and clear: after reset and after every clear request the tag RAM is
//   swept one line per cycle; no request is taken meanwhile.
// Stalls: a finished result waits in the output register while the next
//   request is read; that request holds in the compare stage until it drains.

module direct_mapped_cache_hit_tracker #(
    parameter int MAX_LINES = 16384,
    parameter int TAG_WIDTH = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    dmct_access_if.sink   access,
    dmct_result_if.source result,
    dmct_cfg_if.sink      cfg
);

    import dmct_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LINES);
    localparam int WORD_W = TAG_WIDTH + 1;   // {valid, tag}
    localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(MAX_LINES - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LOOK  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      sweep_reg, sweep_next;
    logic [CFG_DATA_W-1:0] offset_bits_reg, index_bits_reg;
    logic [COUNT_W-1:0]    hit_reg, hit_next;
    logic [COUNT_W-1:0]    miss_reg, miss_next;
    logic                  out_valid_reg, out_valid_next;
    outcome_t              outcome_reg, outcome_next;

    // request held for the compare stage
    mode_t                 mode_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [TAG_WIDTH-1:0]  tag_reg;

    // address split
    logic [CFG_DATA_W-1:0] ob, ib;
    logic [ADDR_W-1:0]     line_addr;
    logic [ADDR_W-1:0]     idx_mask;
    logic [ADDR_W-1:0]     tag_full;
    logic [IDX_W-1:0]      idx_new;
    logic [TAG_WIDTH-1:0]  tag_new;

    // tag RAM
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata;
    logic                  rd_valid;
    logic [TAG_WIDTH-1:0]  rd_tag;

    logic                  accept;
    logic                  out_free;

    assign cfg.ready    = 1'b1;
    assign access.ready = (state_reg == ST_IDLE);
    assign accept       = access.valid && access.ready;
    assign out_free     = !out_valid_reg || result.ready;

    // Config registers are read raw and clamped where used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_RESET;
            index_bits_reg  <= INDEX_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_OFFSET_BITS)
            begin
                offset_bits_reg <= cfg.data;
            end
            else if (cfg.index == CFG_INDEX_BITS)
            begin
                index_bits_reg <= cfg.data;
            end
        end
    end

    // Line address = address >> offset; index = low bits; tag = the rest,
    // kept to TAG_WIDTH bits so wider tags alias.
    always_comb
    begin
        ob        = clamp4(offset_bits_reg, OFFSET_MIN, OFFSET_MAX);
        ib        = clamp4(index_bits_reg, INDEX_MIN, INDEX_MAX);
        line_addr = access.address >> ob;
        idx_mask  = (ADDR_W'(1) << ib) - ADDR_W'(1);
        idx_new   = IDX_W'(line_addr & idx_mask);
        tag_full  = line_addr >> ib;
        tag_new   = tag_full[TAG_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= access.mode;
            idx_reg  <= idx_new;
            tag_reg  <= tag_new;
        end
    end

    assign ram_re   = accept;
    assign rd_valid = ram_rdata[TAG_WIDTH];
    assign rd_tag   = ram_rdata[TAG_WIDTH-1:0];

    dmct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_new),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        hit_next       = hit_reg;
        miss_next      = miss_reg;
        outcome_next   = outcome_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = {1'b1, tag_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_CLEAR)
                    begin
                        hit_next     = '0;
                        miss_next    = '0;
                        outcome_next = OUT_CLEARED;
                        sweep_next   = '0;
                        state_next   = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (rd_valid && (rd_tag == tag_reg))
                        begin
                            outcome_next = OUT_HIT;
                            hit_next     = (hit_reg == '1) ? hit_reg
                                                           : hit_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            outcome_next = rd_valid ? OUT_CONFLICT : OUT_COMPULSORY;
                            miss_next    = (miss_reg == '1) ? miss_reg
                                                            : miss_reg + COUNT_W'(1);
                            ram_we       = 1'b1;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '0;
                sweep_next = sweep_reg + IDX_W'(1);
                if (sweep_reg == LAST_LINE)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
            outcome_reg   <= OUT_HIT;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            hit_reg       <= hit_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
            outcome_reg   <= outcome_next;
        end
    end

    // Counters only change when a result is loaded, so they double as payload.
    assign result.valid      = out_valid_reg;
    assign result.outcome    = outcome_reg;
    assign result.hit_total  = hit_reg;
    assign result.miss_total = miss_reg;

    // ---- checks ----
    a_no_rw_collision : assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("tag RAM read and write in the same cycle");

    a_cleared_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && outcome_reg == OUT_CLEARED) |-> (hit_reg == '0 && miss_reg == '0))
        else $error("cleared result with nonzero totals");

    a_hit_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg) == ST_LOOK && hit_reg != '0)
            |-> hit_reg >= $past(hit_reg))
        else $error("hit count went down without a clear");

    a_look_leaves : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK && out_free) |=> (state_reg != ST_LOOK && out_valid_reg))
        else $error("compare stage did not retire with a free output register");

endmodule

>>> sim/direct_mapped_cache_hit_tracker_tb.sv
// Self-checking testbench for direct_mapped_cache_hit_tracker: directed and random access
// and clear requests, with a scoreboard that tracks the tag store and hit/miss totals.
// Depends on dmct_pkg, dmct_if and the RTL of the tracker.

module direct_mapped_cache_hit_tracker_tb;
    import dmct_pkg::*;

    localparam int MAX_LINES      = 16384;
    localparam int TAG_WIDTH      = 20;
    localparam int LONG_HOLD      = 300;    // receiver hold-off, cycles
    localparam int SETTLE_CYCLES  = 4;      // tag read and compare stages plus margin
    // a clear or reset sweep writes every tag RAM line with nothing accepted
    localparam int WATCHDOG_LIMIT = 4 * MAX_LINES;

    typedef struct {
        outcome_t           outcome;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
    } tracker_result_t;

    // Scoreboard: mirrors the tag store and counters, queues predicted results.
    class hit_tracker_scoreboard;
        bit                   line_valid_q [MAX_LINES];
        logic [TAG_WIDTH-1:0] line_tag_q   [MAX_LINES];
        logic [COUNT_W-1:0]   hits;
        logic [COUNT_W-1:0]   misses;
        logic [CFG_DATA_W-1:0] offset_reg;
        logic [CFG_DATA_W-1:0] index_reg;
        tracker_result_t      pending_results[$];
        int                   mismatches;

        function new();
            foreach (line_valid_q[i])
            begin
                line_valid_q[i] = 1'b0;
            end
            hits       = '0;
            misses     = '0;
            offset_reg = OFFSET_RESET;
            index_reg  = INDEX_RESET;
            mismatches = 0;
        endfunction

        function logic [CFG_DATA_W-1:0] bound(logic [CFG_DATA_W-1:0] v,
                                              logic [CFG_DATA_W-1:0] lo,
                                              logic [CFG_DATA_W-1:0] hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_OFFSET_BITS)
            begin
                offset_reg = value;
            end
            else if (idx == CFG_INDEX_BITS)
            begin
                index_reg = value;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Accepted request: update the mirrored store, queue the predicted result.
        function void note_request(mode_t mode, logic [ADDR_W-1:0] address);
            tracker_result_t       res;
            logic [CFG_DATA_W-1:0] ob;
            logic [CFG_DATA_W-1:0] ib;
            logic [ADDR_W-1:0]     line_addr;
            int unsigned           slot;
            logic [TAG_WIDTH-1:0]  tag;
            if (mode == MODE_CLEAR)
            begin
                foreach (line_valid_q[i])
                begin
                    line_valid_q[i] = 1'b0;
                end
                hits        = '0;
                misses      = '0;
                res.outcome = OUT_CLEARED;
            end
            else
            begin
                // out-of-range register values are pinned to the legal split
                ob        = bound(offset_reg, OFFSET_MIN, OFFSET_MAX);
                ib        = bound(index_reg, INDEX_MIN, INDEX_MAX);
                line_addr = address >> ob;
                slot      = (line_addr & ((32'd1 << ib) - 1)) & (MAX_LINES - 1);
                tag       = TAG_WIDTH'(line_addr >> ib);   // high tag bits alias
                if (!line_valid_q[slot])
                begin
                    line_valid_q[slot] = 1'b1;
                    line_tag_q[slot]   = tag;
                    if (misses != '1) misses++;
                    res.outcome = OUT_COMPULSORY;
                end
                else if (line_tag_q[slot] == tag)
                begin
                    if (hits != '1) hits++;
                    res.outcome = OUT_HIT;
                end
                else
                begin
                    line_tag_q[slot] = tag;
                    if (misses != '1) misses++;
                    res.outcome = OUT_CONFLICT;
                end
            end
            res.hit_total   = hits;
            res.miss_total  = misses;
            pending_results = {pending_results, res};
        endfunction

        function void check_result(outcome_t outcome, logic [COUNT_W-1:0] hit_total,
                                   logic [COUNT_W-1:0] miss_total);
            tracker_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none pending: outcome=%0d hits=%0d misses=%0d",
                         $time, outcome, hit_total, miss_total);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (outcome !== want.outcome)
            begin
                $display("%0t: outcome mismatch: expected %0d, got %0d",
                         $time, want.outcome, outcome);
                mismatches++;
            end
            if (hit_total !== want.hit_total)
            begin
                $display("%0t: hit_total mismatch: expected %0d, got %0d",
                         $time, want.hit_total, hit_total);
                mismatches++;
            end
            if (miss_total !== want.miss_total)
            begin
                $display("%0t: miss_total mismatch: expected %0d, got %0d",
                         $time, want.miss_total, miss_total);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dmct_access_if req_ch ();
    dmct_result_if res_ch ();
    dmct_cfg_if    cfg_ch ();

    direct_mapped_cache_hit_tracker #(
        .MAX_LINES (MAX_LINES),
        .TAG_WIDTH (TAG_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (req_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    hit_tracker_scoreboard sb;

    // idle/stall knobs, percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_kick     = 1'b0;   // asks the receiver for one long hold-off
    int hold_left     = 0;
    int stall_cycles  = 0;

    // recent addresses, so random traffic revisits lines
    logic [ADDR_W-1:0] addr_pool [16];
    int                pool_fill = 0;

    // clock: period 4
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // every input known from time 0
    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.mode    = MODE_ACCESS;
        req_ch.address = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_OFFSET_BITS;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b0;
    end

    // Receiver: random stalls, plus a long hold counted here so that the
    // sender keeps offering and the block backs up into its input.
    always @(negedge clk)
    begin
        if (hold_kick)
        begin
            hold_left = LONG_HOLD;
            hold_kick = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Result monitor, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            sb.check_result(res_ch.outcome, res_ch.hit_total, res_ch.miss_total);
        end
    end

    // Watchdog: too long with no handshake on any channel ends the run.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, nothing accepted for %0d cycles",
                         $time, stall_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // One request. Valid stays up after acceptance; the next request replaces
    // it or a drain takes it down at a later falling edge.
    task automatic send_request(mode_t mode, logic [ADDR_W-1:0] address);
        @(negedge clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= mode;
        req_ch.address <= address;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_request(mode, address);
    endtask

    // Stop offering, wait for every predicted result, then let the pipe settle.
    task automatic drain_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // only called with the block drained
    task automatic set_split(logic [CFG_DATA_W-1:0] offset_val,
                             logic [CFG_DATA_W-1:0] index_val);
        write_reg(CFG_OFFSET_BITS, offset_val);
        write_reg(CFG_INDEX_BITS, index_val);
    endtask

    // Random request: mostly revisits of recent addresses (hits), tag flips
    // (conflicts, or aliases above the stored tag width), neighbor blocks,
    // fully random addresses, and a rare clear.
    function automatic void next_request(output mode_t mode, output logic [ADDR_W-1:0] address);
        int                roll;
        logic [ADDR_W-1:0] base;
        roll    = $urandom_range(99);
        mode    = MODE_ACCESS;
        address = $urandom;
        if (roll == 0)
        begin
            mode = MODE_CLEAR;
        end
        else if (pool_fill == 0 || roll < 16)
        begin
            if (pool_fill < 16)
            begin
                addr_pool[pool_fill] = address;
                pool_fill++;
            end
            else
            begin
                addr_pool[$urandom_range(15)] = address;
            end
        end
        else
        begin
            base = addr_pool[$urandom_range(pool_fill - 1)];
            if (roll < 66)
                address = base ^ ADDR_W'($urandom_range(15));
            else if (roll < 86)
                address = base ^ (32'd1 << $urandom_range(31, 12));
            else
                address = base + ADDR_W'($urandom_range(8, 1) << 8);
        end
    endfunction

    task automatic run_phase(int count, int src_pct, int snk_pct, bit long_hold,
                             bit mid_drain);
        mode_t             mode;
        logic [ADDR_W-1:0] address;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (long_hold)
            hold_kick = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            // sender pause until everything outstanding has come back
            if (mid_drain && i == count / 2)
                drain_requests();
            next_request(mode, address);
            send_request(mode, address);
        end
        drain_requests();
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset split (offset 4, index 8). First request waits out
        // the post-reset sweep through the handshake.
        send_request(MODE_ACCESS, 32'h0000_0000);   // compulsory
        send_request(MODE_ACCESS, 32'h0000_000F);   // same block: hit
        send_request(MODE_ACCESS, 32'h0000_1000);   // same line, new tag: conflict
        send_request(MODE_ACCESS, 32'h0000_0000);   // back again: conflict
        send_request(MODE_ACCESS, 32'hFFFF_FFFF);   // top line
        send_request(MODE_ACCESS, 32'hFFFF_FFF0);   // hit
        send_request(MODE_CLEAR,  32'hFFFF_FFFF);   // address ignored on clear
        send_request(MODE_ACCESS, 32'h0000_0000);   // compulsory again after clear
        drain_requests();

        // smallest split: tag bits above the stored width alias into hits
        set_split(OFFSET_MIN, INDEX_MIN);
        send_request(MODE_ACCESS, 32'h0000_0010);
        send_request(MODE_ACCESS, 32'h8000_0010);   // differs only at bit 31
        send_request(MODE_ACCESS, 32'h0010_0010);   // differs inside the tag
        drain_requests();

        // widest split, lines kept from the old split
        set_split(OFFSET_MAX, INDEX_MAX);
        send_request(MODE_ACCESS, 32'h0000_0010);
        send_request(MODE_ACCESS, 32'hFFFF_FF00);
        send_request(MODE_ACCESS, 32'h0040_0000);
        drain_requests();

        // out-of-range register values, pinned at both ends
        set_split(4'd0, 4'd15);
        send_request(MODE_ACCESS, 32'h1234_5678);
        send_request(MODE_ACCESS, 32'h1234_5670);
        drain_requests();
        set_split(4'd15, 4'd0);
        send_request(MODE_ACCESS, 32'hABCD_EF00);
        send_request(MODE_ACCESS, 32'hABCD_EFFF);
        send_request(MODE_CLEAR,  32'h0000_0000);
        send_request(MODE_ACCESS, 32'h5555_5555);
        send_request(MODE_ACCESS, 32'hAAAA_AAAA);
        drain_requests();

        // Random phases: each sets a split and an idle pattern.
        set_split(OFFSET_RESET, INDEX_RESET);
        run_phase(110, 0, 0, 1'b1, 1'b0);           // long receiver hold-off
        set_split(OFFSET_MAX, INDEX_MAX);
        run_phase(110, 71, 0, 1'b0, 1'b1);          // sender pause mid-phase
        set_split(OFFSET_MIN, INDEX_MIN);
        run_phase(110, 0, 71, 1'b0, 1'b0);
        set_split(OFFSET_MAX, INDEX_MIN);
        run_phase(110, 16, 16, 1'b0, 1'b0);
        set_split(4'd0, 4'd15);
        run_phase(110, 0, 0, 1'b0, 1'b0);
        set_split(4'd15, 4'd0);
        run_phase(110, 71, 0, 1'b0, 1'b0);
        set_split(CFG_DATA_W'($urandom_range(15)), CFG_DATA_W'($urandom_range(15)));
        run_phase(110, 0, 71, 1'b0, 1'b0);
        set_split(4'd6, 4'd10);
        run_phase(110, 16, 16, 1'b0, 1'b0);

        // drain_requests already waited out the pipe; a few more for strays
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
